FILE: hw/rtl/mdfs_pkg.sv
// Package for the mouse delta fixed-point scaler.
// Holds the input and result word types, register indexes and scaling constants.
// No dependencies.
package mdfs_pkg;

    // Request kinds carried in req_type.
    localparam logic REQ_MOTION = 1'b0;
    localparam logic REQ_SEND   = 1'b1;

    // Configuration register indexes.
    localparam logic [1:0] CFG_GAIN   = 2'd0;
    localparam logic [1:0] CFG_WIDTH  = 2'd1;
    localparam logic [1:0] CFG_HEIGHT = 2'd2;

    localparam logic [31:0] GAIN_RESET = 32'h0001_0000;
    localparam int          FRAC_BITS  = 16;
    localparam logic [15:0] ABS_HALF   = 16'h8000;
    localparam logic [31:0] ABS_MAX    = 32'h7FFF_FFFF;
    localparam logic [31:0] ABS_MIN    = 32'h8000_0000;

    // Quotient bits produced by the divider once the overflow test has passed.
    localparam int          DIV_STEPS  = 31;

    typedef struct packed {
        logic        req_type;
        logic [15:0] delta_x;
        logic [15:0] delta_y;
        logic        is_absolute;
        logic        is_virtual_desktop;
        logic [15:0] cursor_x;
        logic [15:0] cursor_y;
    } mdfs_item_t;

    typedef struct packed {
        logic [31:0] abs_x;
        logic [31:0] abs_y;
    } mdfs_result_t;

endpackage

FILE: hw/rtl/mouse_delta_fixed_point_scaler_unit.sv
// Mouse delta fixed-point scaler: top level with sequencer, shared multiplier and divider.
// Depends on mdfs_pkg for the word types and constants.
//
// A motion word is absorbed in the cycle it is accepted and the block stays ready for the
// next word. A send request that produces a result keeps item_stall high until the pair has
// moved into the output register. The two axes are worked one after the other through one
// shared 32x32 multiplier and one restoring divider that yields one quotient bit per cycle.
// Each axis steps through: multiply, add the remainder, take the magnitude, move the
// position, set up the divider, 31 divider steps and store the result. An axis whose
// position saturates skips its 31 divider steps. A final state moves the pair into the output
// register; a result still waiting there holds the block in that state until it is taken.
// A send request that produces nothing is absorbed without leaving the idle state. A following
// motion word is accepted while the finished result waits to be taken.
module mouse_delta_fixed_point_scaler_unit
    import mdfs_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         item_valid,
    output logic         item_stall,
    input  mdfs_item_t   item,
    output logic         result_valid,
    input  logic         result_stall,
    output mdfs_result_t result,
    input  logic         cfg_valid,
    output logic         cfg_ready,
    input  logic [1:0]   cfg_index,
    input  logic [31:0]  cfg_data
);

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_MUL  = 4'd1;
    localparam logic [3:0] S_REL  = 4'd2;
    localparam logic [3:0] S_ABS  = 4'd3;
    localparam logic [3:0] S_POS  = 4'd4;
    localparam logic [3:0] S_NORM = 4'd5;
    localparam logic [3:0] S_DIV  = 4'd6;
    localparam logic [3:0] S_RES  = 4'd7;
    localparam logic [3:0] S_FIN  = 4'd8;

    logic [3:0]   state_reg, state_next;
    logic         axis_reg;
    logic [4:0]   div_cnt_reg;

    logic [31:0]  gain_reg;
    logic [15:0]  width_reg;
    logic [15:0]  height_reg;
    logic [31:0]  accum_x_reg, accum_y_reg;
    logic [16:0]  frac_x_reg, frac_y_reg;

    logic [15:0]  cursor_x_reg, cursor_y_reg;
    logic         aneg_reg, rneg_reg, pneg_reg, ovf_reg;
    logic [63:0]  prod_reg;
    logic [64:0]  rel_reg;
    logic [63:0]  rmag_reg;
    logic [49:0]  pos_reg;
    logic [15:0]  rem_reg;
    logic [30:0]  quo_reg;
    logic [31:0]  abs_x_reg, abs_y_reg;

    logic         result_valid_reg;
    mdfs_result_t result_reg;

    logic         accept;
    logic         out_free;
    logic [32:0]  sum_x, sum_y;
    logic         motion_skip, send_skip;
    logic [31:0]  acc_sel, amag;
    logic [16:0]  frac_sel;
    logic [64:0]  frac_ext, prod_ext;
    logic [15:0]  res_sel, cursor_sel;
    logic [16:0]  frac_new;
    logic [49:0]  step_ext, cursor_ext;
    logic [49:0]  posmag;
    logic [32:0]  rem_init;
    logic [16:0]  trial;
    logic         qbit;
    logic [31:0]  abs_val;

    assign item_stall   = (state_reg != S_IDLE);
    assign accept       = item_valid && !item_stall;
    assign cfg_ready    = 1'b1;
    assign result_valid = result_valid_reg;
    assign result       = result_reg;
    assign out_free     = !result_valid_reg || !result_stall;

    // Saturating accumulation of motion words.
    assign sum_x = {accum_x_reg[31], accum_x_reg} + {{17{item.delta_x[15]}}, item.delta_x};
    assign sum_y = {accum_y_reg[31], accum_y_reg} + {{17{item.delta_y[15]}}, item.delta_y};
    assign motion_skip = (item.is_absolute && !item.is_virtual_desktop)
                         || (item.delta_x == 16'd0 && item.delta_y == 16'd0);
    assign send_skip = (accum_x_reg == 32'd0 && accum_y_reg == 32'd0)
                       || width_reg == 16'd0 || height_reg == 16'd0;

    // Operand selection for the axis being worked.
    assign acc_sel    = axis_reg ? accum_y_reg : accum_x_reg;
    assign amag       = acc_sel[31] ? (32'd0 - acc_sel) : acc_sel;
    assign frac_sel   = axis_reg ? frac_y_reg : frac_x_reg;
    assign res_sel    = axis_reg ? height_reg : width_reg;
    assign cursor_sel = axis_reg ? cursor_y_reg : cursor_x_reg;

    assign frac_ext   = {{48{frac_sel[16]}}, frac_sel};
    assign prod_ext   = {1'b0, prod_reg};

    // The remainder keeps the sign of the scaled value and its low 16 magnitude bits.
    assign frac_new   = rneg_reg ? (17'd0 - {1'b0, rmag_reg[15:0]}) : {1'b0, rmag_reg[15:0]};
    assign step_ext   = {2'b00, rmag_reg[63:FRAC_BITS]};
    assign cursor_ext = {{34{cursor_sel[15]}}, cursor_sel};

    // The dividend is |pos| * 65536 + 32768. Its top 33 bits decide saturation: the quotient
    // reaches 2^31 exactly when they are not below the resolution.
    assign posmag   = pos_reg[49] ? (50'd0 - pos_reg) : pos_reg;
    assign rem_init = posmag[47:15];

    assign trial = {rem_reg, quo_reg[30]};
    assign qbit  = (trial >= {1'b0, res_sel});

    always_comb
    begin
        if (ovf_reg)
        begin
            abs_val = pneg_reg ? ABS_MIN : ABS_MAX;
        end
        else if (pneg_reg)
        begin
            abs_val = 32'd0 - {1'b0, quo_reg};
        end
        else
        begin
            abs_val = {1'b0, quo_reg};
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (accept && item.req_type == REQ_SEND && !send_skip)
                begin
                    state_next = S_MUL;
                end
            end
            S_MUL:  state_next = S_REL;
            S_REL:  state_next = S_ABS;
            S_ABS:  state_next = S_POS;
            S_POS:  state_next = S_NORM;
            S_NORM:
            begin
                state_next = (rem_init >= {17'd0, res_sel}) ? S_RES : S_DIV;
            end
            S_DIV:
            begin
                if (div_cnt_reg == 5'd1)
                begin
                    state_next = S_RES;
                end
            end
            S_RES:  state_next = axis_reg ? S_FIN : S_MUL;
            S_FIN:
            begin
                if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    // Control and architectural state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            axis_reg         <= 1'b0;
            div_cnt_reg      <= 5'd0;
            gain_reg         <= GAIN_RESET;
            width_reg        <= 16'd0;
            height_reg       <= 16'd0;
            accum_x_reg      <= 32'd0;
            accum_y_reg      <= 32'd0;
            frac_x_reg       <= 17'd0;
            frac_y_reg       <= 17'd0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;

            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    CFG_GAIN:   gain_reg   <= cfg_data;
                    CFG_WIDTH:  width_reg  <= cfg_data[15:0];
                    CFG_HEIGHT: height_reg <= cfg_data[15:0];
                    default:    ;
                endcase
            end

            if (state_reg == S_FIN && out_free)
            begin
                result_valid_reg <= 1'b1;
            end
            else if (result_valid_reg && !result_stall)
            begin
                result_valid_reg <= 1'b0;
            end

            case (state_reg)
                S_IDLE:
                begin
                    axis_reg <= 1'b0;
                    if (accept && item.req_type == REQ_MOTION && !motion_skip)
                    begin
                        if (sum_x[32] != sum_x[31])
                        begin
                            accum_x_reg <= sum_x[32] ? ABS_MIN : ABS_MAX;
                        end
                        else
                        begin
                            accum_x_reg <= sum_x[31:0];
                        end
                        if (sum_y[32] != sum_y[31])
                        begin
                            accum_y_reg <= sum_y[32] ? ABS_MIN : ABS_MAX;
                        end
                        else
                        begin
                            accum_y_reg <= sum_y[31:0];
                        end
                    end
                end
                S_POS:
                begin
                    if (axis_reg)
                    begin
                        frac_y_reg <= frac_new;
                    end
                    else
                    begin
                        frac_x_reg <= frac_new;
                    end
                end
                S_NORM:
                begin
                    div_cnt_reg <= 5'(DIV_STEPS);
                end
                S_DIV:
                begin
                    div_cnt_reg <= div_cnt_reg - 5'd1;
                end
                S_RES:
                begin
                    axis_reg <= 1'b1;
                end
                S_FIN:
                begin
                    if (out_free)
                    begin
                        accum_x_reg <= 32'd0;
                        accum_y_reg <= 32'd0;
                    end
                end
                default: ;
            endcase
        end
    end

    // Datapath registers of the shared multiplier and divider.
    always_ff @(posedge clk)
    begin
        case (state_reg)
            S_IDLE:
            begin
                cursor_x_reg <= item.cursor_x;
                cursor_y_reg <= item.cursor_y;
            end
            S_MUL:
            begin
                aneg_reg <= acc_sel[31];
                prod_reg <= 64'(amag) * 64'(gain_reg);
            end
            S_REL:
            begin
                rel_reg <= aneg_reg ? (frac_ext - prod_ext) : (frac_ext + prod_ext);
            end
            S_ABS:
            begin
                rneg_reg <= rel_reg[64];
                rmag_reg <= rel_reg[64] ? (64'd0 - rel_reg[63:0]) : rel_reg[63:0];
            end
            S_POS:
            begin
                pos_reg <= rneg_reg ? (cursor_ext - step_ext) : (cursor_ext + step_ext);
            end
            S_NORM:
            begin
                pneg_reg <= pos_reg[49];
                ovf_reg  <= (rem_init >= {17'd0, res_sel});
                rem_reg  <= rem_init[15:0];
                quo_reg  <= {posmag[14:0], ABS_HALF};
            end
            S_DIV:
            begin
                // One restoring step: the dividend bits leave at the top, quotient bits
                // enter at the bottom.
                rem_reg <= qbit ? 16'(trial - {1'b0, res_sel}) : trial[15:0];
                quo_reg <= {quo_reg[29:0], qbit};
            end
            S_RES:
            begin
                if (axis_reg)
                begin
                    abs_y_reg <= abs_val;
                end
                else
                begin
                    abs_x_reg <= abs_val;
                end
            end
            S_FIN:
            begin
                if (out_free)
                begin
                    result_reg.abs_x <= abs_x_reg;
                    result_reg.abs_y <= abs_y_reg;
                end
            end
            default: ;
        endcase
    end

endmodule
